/* rtl/acir_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// acir_pkg
// Shared types and constants of the ambient corrected ranger.
// ----------------------------------------------------------------------------
package acir_pkg;

  localparam int SAMPLE_W = 10;
  localparam int COUNT_W  = 7;
  localparam int WEIGHT_W = 9;
  localparam int INDEX_W  = 6;
  localparam int SUM_W    = 16;
  localparam int REFLEX_W = 17;
  localparam int RANGE_W  = 17;
  localparam int ROOT_W   = 16;
  localparam int QUO_W    = 32;

  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 9;

  localparam logic [CFG_INDEX_W-1:0] CFG_READINGS_COUNT = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FILTER_WEIGHT  = 4'd1;

  localparam logic [COUNT_W-1:0]  READINGS_COUNT_RESET = 7'd8;
  localparam logic [COUNT_W-1:0]  MAX_COUNT            = 7'd64;
  localparam logic [WEIGHT_W-1:0] FILTER_WEIGHT_RESET  = 9'd0;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE           = 9'd256;

  localparam int DIV_STEPS  = 32;
  localparam int SQRT_STEPS = 16;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  localparam int DEFAULT_QUEUE_DEPTH = 2;

  // one classified sample handed from the front to the back
  typedef struct packed {
    logic                       emitter_on;
    logic                       measure_done;
    logic signed [REFLEX_W-1:0] reflex;
    logic                       reflection_seen;
    logic [SUM_W-1:0]           peak;
    logic [SUM_W-1:0]           divisor;
  } acir_entry_t;

  typedef struct packed {
    logic                       emitter_on;
    logic                       measure_done;
    logic signed [REFLEX_W-1:0] reflex;
    logic                       reflection_seen;
    logic [RANGE_W-1:0]         range_estimate;
  } acir_result_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_SQRT,
    BK_MUL,
    BK_MIX
  } acir_back_state_t;

endpackage
`default_nettype wire

/* rtl/acir_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// acir_front
// Takes samples, keeps the phase sums and the peak reflex, classifies
// each sample and pushes one entry into the queue.
// ----------------------------------------------------------------------------
module acir_front
  import acir_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [COUNT_W-1:0]  readings_count,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [SAMPLE_W-1:0] sample,
  input  wire logic                queue_full,
  output logic                     push,
  output acir_entry_t              entry
);

  logic               in_emitter_phase;
  logic [INDEX_W-1:0] sample_index;
  logic [SUM_W-1:0]   ambient_sum;
  logic [SUM_W-1:0]   lit_sum;
  logic [SUM_W-1:0]   peak_reflex;

  logic [COUNT_W-1:0]  count_eff;
  logic [COUNT_W-1:0]  index_plus;
  logic                last;
  logic [SUM_W-1:0]    ambient_next;
  logic [SUM_W-1:0]    lit_next;
  logic [REFLEX_W-1:0] diff;
  logic [SUM_W-1:0]    pos_diff;
  logic [SUM_W-1:0]    peak_next;
  logic                seen;

  assign in_ready = !queue_full;
  assign push     = in_valid && in_ready;

  always_comb begin
    if (readings_count == '0) begin
      count_eff = COUNT_W'(1);
    end else if (readings_count > MAX_COUNT) begin
      count_eff = MAX_COUNT;
    end else begin
      count_eff = readings_count;
    end
  end

  assign index_plus = {1'b0, sample_index} + COUNT_W'(1);
  assign last       = index_plus >= count_eff;

  // first sample of a phase restarts its sum
  assign ambient_next = ((sample_index == '0) ? '0 : ambient_sum) + SUM_W'(sample);
  assign lit_next     = ((sample_index == '0) ? '0 : lit_sum) + SUM_W'(sample);

  assign diff      = {1'b0, lit_next} - {1'b0, ambient_sum};
  assign pos_diff  = diff[SUM_W-1:0];
  assign seen      = lit_next > ambient_sum;
  assign peak_next = (pos_diff > peak_reflex) ? pos_diff : peak_reflex;

  always_comb begin
    entry.emitter_on      = in_emitter_phase ? !last : last;
    entry.measure_done    = in_emitter_phase && last;
    entry.reflex          = entry.measure_done ? diff : '0;
    entry.reflection_seen = entry.measure_done && seen;
    entry.peak            = peak_next;
    entry.divisor         = pos_diff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_emitter_phase <= 1'b0;
      sample_index     <= '0;
      ambient_sum      <= '0;
      lit_sum          <= '0;
      peak_reflex      <= '0;
    end else if (push) begin
      if (!in_emitter_phase) begin
        ambient_sum <= ambient_next;
      end else begin
        lit_sum <= lit_next;
      end
      if (entry.reflection_seen) begin
        peak_reflex <= peak_next;
      end
      if (last) begin
        in_emitter_phase <= !in_emitter_phase;
        sample_index     <= '0;
      end else begin
        sample_index <= index_plus[INDEX_W-1:0];
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/acir_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// acir_queue
// Short first-in first-out queue of classified entries between the front
// and the back.
// ----------------------------------------------------------------------------
module acir_queue
  import acir_pkg::*;
#(
  parameter int DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire acir_entry_t push_entry,
  output logic             full,
  input  wire logic        pop,
  output logic             not_empty,
  output acir_entry_t      head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  acir_entry_t       slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  fill;

  assign full      = fill == CNT_W'(DEPTH);
  assign not_empty = fill != '0;
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/acir_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// acir_back
// Works off queued entries: radix-2 divider, digit-by-digit square root,
// smoothing multiply, and the output register.
// ----------------------------------------------------------------------------
module acir_back
  import acir_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [WEIGHT_W-1:0] filter_weight,
  input  wire logic                q_not_empty,
  input  wire acir_entry_t         q_head,
  output logic                     q_pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output acir_result_t             result
);

  acir_back_state_t state;
  acir_back_state_t state_next;

  logic [STEP_W-1:0]     step;
  logic [QUO_W-1:0]      quo;
  logic [SUM_W:0]        rem;
  logic [SUM_W-1:0]      divisor;
  logic [ROOT_W:0]       srem;
  logic [ROOT_W-1:0]     sroot;
  logic [25:0]           prod_prev;
  logic [24:0]           prod_root;
  logic [RANGE_W-1:0]    smoothed_range;
  acir_entry_t           held;

  logic                  out_free;
  logic                  load_plain;
  logic                  load_mix;
  logic                  div_last;
  logic                  sqrt_last;
  logic [SUM_W:0]        rem_sh;
  logic                  div_ge;
  logic [ROOT_W+2:0]     srem_sh;
  logic [ROOT_W+2:0]     trial;
  logic [ROOT_W+2:0]     srem_sub;
  logic                  sqrt_ge;
  logic [WEIGHT_W-1:0]   w_eff;
  logic [WEIGHT_W-1:0]   w_inv;
  logic [26:0]           mix;
  logic [RANGE_W-1:0]    range_new;

  assign out_free  = !out_valid || out_ready;
  assign div_last  = step == STEP_W'(DIV_STEPS - 1);
  assign sqrt_last = step == STEP_W'(SQRT_STEPS - 1);

  assign w_eff = (filter_weight > WEIGHT_ONE) ? WEIGHT_ONE : filter_weight;
  assign w_inv = WEIGHT_ONE - w_eff;

  // restoring divide, one quotient bit per cycle; rem stays below divisor
  assign rem_sh = {rem[SUM_W-1:0], quo[QUO_W-1]};
  assign div_ge = rem_sh >= {1'b0, divisor};

  // square root, two radicand bits per cycle
  assign srem_sh  = {srem, quo[QUO_W-1 -: 2]};
  assign trial    = {1'b0, sroot, 2'b01};
  assign sqrt_ge  = srem_sh >= trial;
  assign srem_sub = srem_sh - trial;

  // round half up, drop the eight weight bits
  assign mix       = {1'b0, prod_prev} + {2'b00, prod_root} + 27'd128;
  assign range_new = mix[RANGE_W+7:8];

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: if (q_not_empty && q_head.reflection_seen) state_next = BK_DIV;
      BK_DIV:  if (div_last) state_next = BK_SQRT;
      BK_SQRT: if (sqrt_last) state_next = BK_MUL;
      BK_MUL:  state_next = BK_MIX;
      BK_MIX:  if (out_free) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop      = 1'b0;
    load_plain = 1'b0;
    load_mix   = 1'b0;
    unique case (state)
      BK_IDLE: begin
        q_pop      = q_not_empty && (q_head.reflection_seen || out_free);
        load_plain = q_not_empty && !q_head.reflection_seen && out_free;
      end
      BK_MIX:  load_mix = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= BK_IDLE;
      smoothed_range <= '0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (load_mix) begin
        smoothed_range <= range_new;
      end
      if (load_plain || load_mix) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        held    <= q_head;
        quo     <= {q_head.peak, {SUM_W{1'b0}}};
        rem     <= '0;
        divisor <= q_head.divisor;
        step    <= '0;
      end
      BK_DIV: begin
        rem  <= div_ge ? rem_sh - {1'b0, divisor} : rem_sh;
        quo  <= {quo[QUO_W-2:0], div_ge};
        step <= div_last ? '0 : step + STEP_W'(1);
        srem  <= '0;
        sroot <= '0;
      end
      BK_SQRT: begin
        srem  <= sqrt_ge ? srem_sub[ROOT_W:0] : srem_sh[ROOT_W:0];
        sroot <= {sroot[ROOT_W-2:0], sqrt_ge};
        quo   <= {quo[QUO_W-3:0], 2'b00};
        step  <= step + STEP_W'(1);
      end
      BK_MUL: begin
        prod_prev <= 26'(smoothed_range) * 26'(w_eff);
        prod_root <= 25'(sroot) * 25'(w_inv);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_plain) begin
      result.emitter_on      <= q_head.emitter_on;
      result.measure_done    <= q_head.measure_done;
      result.reflex          <= q_head.reflex;
      result.reflection_seen <= 1'b0;
      result.range_estimate  <= '0;
    end else if (load_mix) begin
      result.emitter_on      <= held.emitter_on;
      result.measure_done    <= held.measure_done;
      result.reflex          <= held.reflex;
      result.reflection_seen <= 1'b1;
      result.range_estimate  <= range_new;
    end
  end

endmodule
`default_nettype wire

/* rtl/ambient_corrected_isl_ranger_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ambient_corrected_isl_ranger_unit
// Ambient corrected inverse-square-law ranger with exponential smoothing.
// ----------------------------------------------------------------------------
// Every accepted sample gives one output word. A sample that does not close
// a measurement, or closes one without a reflection, leaves the back end from
// its idle state once it heads the queue and the output register is free.
// A closing sample with a reflection passes through the idle state that loads
// it, the radix-2 divider that forms peak/reflex, the square root, a multiply
// step and a round-and-store step. The front keeps taking samples while the
// queue (QUEUE_DEPTH words) has room, so the sustained rate is set by the
// divider and root unit once per measurement. Configuration writes are always
// accepted; there is no clearing pass after reset. emitter_on in each output
// word is the drive for the next sample.
// ----------------------------------------------------------------------------
module ambient_corrected_isl_ranger_unit
  import acir_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [15:0]            s_tdata,   // [9:0] sample
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [39:0]                 m_tdata,   // [0] emitter_on, [17:1] reflex,
                                                 // [18] reflection_seen,
                                                 // [35:19] range_estimate
  output logic                        m_tlast    // measure_done
);

  logic [COUNT_W-1:0]  readings_count;
  logic [WEIGHT_W-1:0] filter_weight;

  acir_entry_t  push_entry;
  acir_entry_t  head;
  acir_result_t result;
  logic         push;
  logic         full;
  logic         pop;
  logic         not_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      readings_count <= READINGS_COUNT_RESET;
      filter_weight  <= FILTER_WEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_READINGS_COUNT: readings_count <= cfg_data[COUNT_W-1:0];
        CFG_FILTER_WEIGHT:  filter_weight  <= cfg_data[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  acir_front u_front (
    .clk            (clk),
    .rst            (rst),
    .readings_count (readings_count),
    .in_valid       (s_tvalid),
    .in_ready       (s_tready),
    .sample         (s_tdata[SAMPLE_W-1:0]),
    .queue_full     (full),
    .push           (push),
    .entry          (push_entry)
  );

  acir_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .not_empty  (not_empty),
    .head       (head)
  );

  acir_back u_back (
    .clk           (clk),
    .rst           (rst),
    .filter_weight (filter_weight),
    .q_not_empty   (not_empty),
    .q_head        (head),
    .q_pop         (pop),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .result        (result)
  );

  assign m_tdata = {4'b0000, result.range_estimate, result.reflection_seen,
                    result.reflex, result.emitter_on};
  assign m_tlast = result.measure_done;

endmodule
`default_nettype wire

/* rtl/acir_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// acir_checker
// Port-level checks on the output words of the ranger.
// ----------------------------------------------------------------------------
module acir_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata,
  input wire logic        m_tlast
);

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output word changed while stalled");

  // a word that closes no measurement carries no reflex and no range
  a_open_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata[35:1] == 35'd0)
    else $error("open sample carries measurement fields");

  // a seen reflection means a closed measurement with positive reflex
  a_seen_pos: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[18] |-> m_tlast && !m_tdata[17] && m_tdata[17:1] != 17'd0)
    else $error("reflection without positive reflex");

  // closing a measurement always returns the emitter to dark
  a_dark_after: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> !m_tdata[0])
    else $error("emitter left lit after measurement");

  a_no_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[18] |-> m_tdata[35:19] == 17'd0 && m_tdata[39:36] == 4'd0)
    else $error("range without reflection");

endmodule

bind ambient_corrected_isl_ranger_unit acir_checker u_acir_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
`default_nettype wire

/* dv/tb_ambient_corrected_isl_ranger_unit.sv */
// ----------------------------------------------------------------------------
// tb_ambient_corrected_isl_ranger_unit
// Self-checking bench for the ambient corrected ranger. A directed table
// covers the reset state, sample extremes, negative and zero reflex,
// count and weight extremes, masked and unknown register writes and a count
// lowered mid-phase; randomized phases follow, each may write new settings.
// Typed table rows are checked against their table words, the rest against an
// in-bench model of measurement, peak tracking, fixed-point root, smoothing.
// ----------------------------------------------------------------------------
module tb_ambient_corrected_isl_ranger_unit;
  import acir_pkg::*;

  localparam int RANDOM_ITEMS = 2000;
  localparam int SETTLE_CYCLES = 60;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 4'd15;

  typedef enum logic { ROW_SAMPLE, ROW_WRITE } row_kind_t;

  typedef struct packed {
    row_kind_t                kind;
    logic [CFG_INDEX_W-1:0]   idx;
    logic [SAMPLE_W-1:0]      value;
    logic                     typed;
    acir_result_t             want;
  } dir_row_t;

  localparam acir_result_t DARK_WORD = '{1'b0, 1'b0, 17'sd0, 1'b0, 17'd0};
  localparam acir_result_t LIT_WORD  = '{1'b1, 1'b0, 17'sd0, 1'b0, 17'd0};

  dir_row_t dir_table [28] = '{
    '{ROW_SAMPLE, 4'd0, 10'd1023, 1'b1, DARK_WORD},
    '{ROW_SAMPLE, 4'd0, 10'd0,    1'b0, DARK_WORD},
    '{ROW_SAMPLE, 4'd0, 10'd512,  1'b0, DARK_WORD},
    '{ROW_SAMPLE, 4'd0, 10'd341,  1'b0, DARK_WORD},
    // count lowered below the current position: next sample ends the phase
    '{ROW_WRITE,  CFG_READINGS_COUNT, 10'd3, 1'b0, DARK_WORD},
    '{ROW_SAMPLE, 4'd0, 10'd682,  1'b1, LIT_WORD},
    // upper data bits fall outside the count register
    '{ROW_WRITE,  CFG_READINGS_COUNT, 10'h181, 1'b0, DARK_WORD},
    '{ROW_SAMPLE, 4'd0, 10'd1023, 1'b1, '{1'b0, 1'b1, -17'sd1535, 1'b0, 17'd0}},
    '{ROW_SAMPLE, 4'd0, 10'd0,    1'b1, LIT_WORD},
    '{ROW_SAMPLE, 4'd0, 10'd1023, 1'b1, '{1'b0, 1'b1, 17'sd1023, 1'b1, 17'd256}},
    '{ROW_SAMPLE, 4'd0, 10'd1023, 1'b1, LIT_WORD},
    '{ROW_SAMPLE, 4'd0, 10'd0,    1'b1, '{1'b0, 1'b1, -17'sd1023, 1'b0, 17'd0}},
    '{ROW_SAMPLE, 4'd0, 10'd0,    1'b1, LIT_WORD},
    '{ROW_SAMPLE, 4'd0, 10'd1,    1'b0, DARK_WORD},
    '{ROW_WRITE,  CFG_FILTER_WEIGHT, 10'd256, 1'b0, DARK_WORD},
    '{ROW_SAMPLE, 4'd0, 10'd600,  1'b1, LIT_WORD},
    '{ROW_SAMPLE, 4'd0, 10'd600,  1'b1, '{1'b0, 1'b1, 17'sd0, 1'b0, 17'd0}},
    '{ROW_SAMPLE, 4'd0, 10'd0,    1'b0, DARK_WORD},
    '{ROW_SAMPLE, 4'd0, 10'd1023, 1'b0, DARK_WORD},
    '{ROW_WRITE,  CFG_FILTER_WEIGHT, 10'd511, 1'b0, DARK_WORD},
    '{ROW_WRITE,  CFG_SPARE_HI, 10'h1FF, 1'b0, DARK_WORD},
    '{ROW_WRITE,  CFG_SPARE_LO, 10'd0,   1'b0, DARK_WORD},
    '{ROW_WRITE,  CFG_FILTER_WEIGHT, 10'd128, 1'b0, DARK_WORD},
    '{ROW_SAMPLE, 4'd0, 10'd7,    1'b0, DARK_WORD},
    '{ROW_SAMPLE, 4'd0, 10'd900,  1'b0, DARK_WORD},
    '{ROW_WRITE,  CFG_READINGS_COUNT, 10'd0, 1'b0, DARK_WORD},
    '{ROW_SAMPLE, 4'd0, 10'd0,    1'b0, DARK_WORD},
    '{ROW_SAMPLE, 4'd0, 10'd2,    1'b0, DARK_WORD}
  };

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [15:0]            s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [39:0]            m_tdata;
  logic                   m_tlast;

  // model state and register copies
  logic [COUNT_W-1:0]  count_reg;
  logic [WEIGHT_W-1:0] weight_reg;
  logic                lit_phase;
  logic [INDEX_W-1:0]  pos;
  logic [SUM_W-1:0]    dark_acc;
  logic [SUM_W-1:0]    lit_acc;
  logic [SUM_W-1:0]    peak_seen;
  logic [RANGE_W-1:0]  range_avg;

  acir_result_t pending_words [$];
  acir_result_t got_word;
  acir_result_t want_word;

  bit  calm;
  int  hold_left;
  int  error_count;
  int  samples_sent;
  int  measures_seen;
  int  echoes_seen;
  int  writes_done;

  ambient_corrected_isl_ranger_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  always #10 clk = ~clk;

  function automatic int unsigned eff_count();
    if (count_reg == 0) return 1;
    if (count_reg > MAX_COUNT) return 64;
    return 32'(count_reg);
  endfunction

  // largest x with x*x <= v, bit by bit from the top
  function automatic int unsigned floor_root(input longint unsigned v);
    int unsigned x;
    int unsigned t;
    x = 0;
    for (int b = 15; b >= 0; b--) begin
      t = x | (32'd1 << b);
      if (64'(t) * 64'(t) <= v) x = t;
    end
    return x;
  endfunction

  function automatic acir_result_t ranger_step(input logic [SAMPLE_W-1:0] v);
    acir_result_t    res;
    int unsigned     cnt;
    int unsigned     w;
    int unsigned     diff;
    int unsigned     root;
    longint unsigned quo;
    longint unsigned mix;
    bit              closing;
    res = '0;
    cnt = eff_count();
    w = (weight_reg > WEIGHT_ONE) ? 256 : 32'(weight_reg);
    closing = (int'(pos) + 1) >= cnt;
    if (!lit_phase) begin
      dark_acc = ((pos == 0) ? 16'd0 : dark_acc) + SUM_W'(v);
      if (closing) begin
        lit_phase = 1'b1;
        pos = '0;
      end else begin
        pos = pos + INDEX_W'(1);
      end
    end else begin
      lit_acc = ((pos == 0) ? 16'd0 : lit_acc) + SUM_W'(v);
      if (closing) begin
        res.measure_done = 1'b1;
        res.reflex = {1'b0, lit_acc} - {1'b0, dark_acc};
        if (lit_acc > dark_acc) begin
          diff = 32'(lit_acc) - 32'(dark_acc);
          res.reflection_seen = 1'b1;
          if (diff > 32'(peak_seen)) peak_seen = diff[SUM_W-1:0];
          quo = (64'(peak_seen) << 16) / 64'(diff);
          root = floor_root(quo);
          mix = 64'(range_avg) * 64'(w) + 64'(root) * 64'(256 - w) + 64'd128;
          range_avg = mix[RANGE_W+7:8];
          res.range_estimate = range_avg;
        end
        lit_phase = 1'b0;
        pos = '0;
      end else begin
        pos = pos + INDEX_W'(1);
      end
    end
    res.emitter_on = lit_phase;
    return res;
  endfunction

  task automatic send_sample(input logic [SAMPLE_W-1:0] v, input bit typed,
                             input acir_result_t typed_want);
    int           gap;
    acir_result_t predicted;
    gap = calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, v};
    do @(posedge clk); while (!s_tready);
    predicted = ranger_step(v);
    pending_words.push_back(typed ? typed_want : predicted);
    samples_sent++;
  endtask

  // hold the sender until the block has returned every word
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_READINGS_COUNT) count_reg = data[COUNT_W-1:0];
    else if (idx == CFG_FILTER_WEIGHT) weight_reg = data;
    writes_done++;
    // stay idle so a following write starts on a later edge
    @(posedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) begin
      return lit_phase ? SAMPLE_W'($urandom_range(200, 1023))
                       : SAMPLE_W'($urandom_range(0, 500));
    end
    if (sel == 7) return $urandom_range(0, 1) ? 10'd1023 : 10'd0;
    return SAMPLE_W'($urandom_range(0, 1023));
  endfunction

  // receiver: fresh stall drawn after every accepted word
  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 1'b0;
      hold_left = 0;
    end else if (m_tvalid && m_tready) begin
      hold_left = calm ? 0 : $urandom_range(0, 10);
      m_tready <= (hold_left == 0);
    end else if (!m_tready) begin
      if (hold_left == 0) m_tready <= 1'b1;
      else hold_left = hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_word.emitter_on      = m_tdata[0];
      got_word.measure_done    = m_tlast;
      got_word.reflex          = m_tdata[17:1];
      got_word.reflection_seen = m_tdata[18];
      got_word.range_estimate  = m_tdata[35:19];
      if (m_tlast) measures_seen++;
      if (m_tdata[18]) echoes_seen++;
      if (pending_words.size() == 0) begin
        $error("output word with nothing expected: %h", m_tdata);
        error_count++;
      end else begin
        want_word = pending_words.pop_front();
        if (got_word.emitter_on != want_word.emitter_on) begin
          $error("emitter_on: expected %0d, got %0d", want_word.emitter_on,
                 got_word.emitter_on);
          error_count++;
        end
        if (got_word.measure_done != want_word.measure_done) begin
          $error("measure_done: expected %0d, got %0d", want_word.measure_done,
                 got_word.measure_done);
          error_count++;
        end
        if (got_word.reflex != want_word.reflex) begin
          $error("reflex: expected %0d, got %0d", want_word.reflex, got_word.reflex);
          error_count++;
        end
        if (got_word.reflection_seen != want_word.reflection_seen) begin
          $error("reflection_seen: expected %0d, got %0d",
                 want_word.reflection_seen, got_word.reflection_seen);
          error_count++;
        end
        if (got_word.range_estimate != want_word.range_estimate) begin
          $error("range_estimate: expected %0d, got %0d",
                 want_word.range_estimate, got_word.range_estimate);
          error_count++;
        end
      end
    end
  end

  initial begin
    #(20_000_000);
    $display("ambient_corrected_isl_ranger_unit regression: fail");
    $finish;
  end

  initial begin
    int                  phase;
    int                  batch;
    int                  random_sent;
    int                  sel;
    logic [CFG_DATA_W-1:0] data;
    count_reg  = READINGS_COUNT_RESET;
    weight_reg = FILTER_WEIGHT_RESET;
    lit_phase  = 1'b0;
    pos        = '0;
    dark_acc   = '0;
    lit_acc    = '0;
    peak_seen  = '0;
    range_avg  = '0;
    calm = 1'b0;
    error_count = 0;
    samples_sent = 0;
    measures_seen = 0;
    echoes_seen = 0;
    writes_done = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_table[i]) begin
      if (dir_table[i].kind == ROW_WRITE) begin
        drain();
        write_reg(dir_table[i].idx, dir_table[i].value[CFG_DATA_W-1:0]);
      end else begin
        send_sample(dir_table[i].value, dir_table[i].typed, dir_table[i].want);
      end
    end

    phase = 0;
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      drain();
      calm = ($urandom_range(0, 3) == 0);
      // first phases pin the count and weight extremes
      case (phase)
        0: begin
          write_reg(CFG_READINGS_COUNT, 9'd64);
          write_reg(CFG_FILTER_WEIGHT, 9'd0);
        end
        1: begin
          write_reg(CFG_READINGS_COUNT, 9'd127);
          write_reg(CFG_FILTER_WEIGHT, 9'd256);
        end
        default: begin
          sel = $urandom_range(0, 9);
          if (sel == 0) data = 9'd0;
          else if (sel == 1) data = CFG_DATA_W'($urandom_range(0, 511));
          else if (sel < 4) data = CFG_DATA_W'($urandom_range(1, 64));
          else data = CFG_DATA_W'($urandom_range(1, 6));
          if ($urandom_range(0, 2) != 0) write_reg(CFG_READINGS_COUNT, data);
          sel = $urandom_range(0, 7);
          if (sel == 0) data = WEIGHT_ONE;
          else if (sel == 1) data = 9'd0;
          else data = CFG_DATA_W'($urandom_range(0, 511));
          if ($urandom_range(0, 2) != 0) write_reg(CFG_FILTER_WEIGHT, data);
          if ($urandom_range(0, 9) == 0) begin
            write_reg(CFG_INDEX_W'($urandom_range(2, 15)),
                      CFG_DATA_W'($urandom_range(0, 511)));
          end
        end
      endcase
      // some batches stop mid-phase so later count writes land there
      batch = $urandom_range(1, 3) * 2 * eff_count() + $urandom_range(0, 5);
      repeat (batch) begin
        send_sample(pick_sample(), 1'b0, DARK_WORD);
        random_sent++;
      end
      phase++;
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("run covered %0d samples over %0d setting phases and %0d register writes;",
             samples_sent, phase, writes_done);
    $display("%0d measurements closed, %0d of them with a reflection",
             measures_seen, echoes_seen);
    if (error_count == 0 && pending_words.size() == 0) begin
      $display("ambient_corrected_isl_ranger_unit regression: pass");
    end else begin
      $display("ambient_corrected_isl_ranger_unit regression: fail");
    end
    $finish;
  end

endmodule
